FILE: design/csi_pkg.sv
`default_nettype none

package csi_pkg;

    // Result kinds
    localparam logic [2:0] KIND_CHAR         = 3'd0;
    localparam logic [2:0] KIND_ATTRIBUTE    = 3'd1;
    localparam logic [2:0] KIND_CLEAR_LINE   = 3'd2;
    localparam logic [2:0] KIND_CLEAR_SCREEN = 3'd3;
    localparam logic [2:0] KIND_CURSOR       = 3'd4;
    localparam logic [2:0] KIND_COLUMNS      = 3'd5;
    localparam logic [2:0] KIND_VISIBILITY   = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] REG_INIT_ATTR    = 3'd0;
    localparam logic [2:0] REG_WIN_LEFT     = 3'd1;
    localparam logic [2:0] REG_WIN_TOP      = 3'd2;
    localparam logic [2:0] REG_WIN_RIGHT    = 3'd3;
    localparam logic [2:0] REG_WIN_BOTTOM   = 3'd4;

    localparam logic [7:0]  RESET_ATTR       = 8'd7;
    localparam logic [14:0] RESET_WIN_RIGHT  = 15'd79;
    localparam logic [14:0] RESET_WIN_BOTTOM = 15'd24;

    // Private modifiers
    localparam logic [1:0] MOD_NONE    = 2'd0;
    localparam logic [1:0] MOD_QUERY   = 2'd1;
    localparam logic [1:0] MOD_GREATER = 2'd2;

    // Clear modes
    localparam logic [1:0] CLR_TO_END     = 2'd0;
    localparam logic [1:0] CLR_FROM_START = 2'd1;
    localparam logic [1:0] CLR_ALL        = 2'd2;

    // Stream bytes
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_DIGIT_0  = 8'h30;
    localparam logic [7:0] CH_DIGIT_9  = 8'h39;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_QUERY    = 8'h3F;
    localparam logic [7:0] CH_GREATER  = 8'h3E;
    localparam logic [7:0] CH_SGR      = 8'h6D;
    localparam logic [7:0] CH_EL       = 8'h4B;
    localparam logic [7:0] CH_ED       = 8'h4A;
    localparam logic [7:0] CH_CUP      = 8'h48;
    localparam logic [7:0] CH_HVP      = 8'h66;
    localparam logic [7:0] CH_SET      = 8'h68;
    localparam logic [7:0] CH_RESET    = 8'h6C;

    // SGR parameter codes
    localparam logic [15:0] SGR_DEFAULT      = 16'd0;
    localparam logic [15:0] SGR_BOLD         = 16'd1;
    localparam logic [15:0] SGR_UNDERLINE    = 16'd4;
    localparam logic [15:0] SGR_BLINK        = 16'd5;
    localparam logic [15:0] SGR_REVERSE      = 16'd7;
    localparam logic [15:0] SGR_NORMAL       = 16'd22;
    localparam logic [15:0] SGR_NO_UNDERLINE = 16'd24;
    localparam logic [15:0] SGR_NO_BLINK     = 16'd25;
    localparam logic [15:0] SGR_NO_REVERSE   = 16'd27;
    localparam logic [15:0] SGR_FG_FIRST     = 16'd30;
    localparam logic [15:0] SGR_FG_LAST      = 16'd37;
    localparam logic [15:0] SGR_BG_FIRST     = 16'd40;
    localparam logic [15:0] SGR_BG_LAST      = 16'd47;
    localparam logic [15:0] SGR_DEFAULT_ALT  = 16'd100;

    // Mode parameter codes
    localparam logic [15:0] MODE_COLUMNS    = 16'd3;
    localparam logic [15:0] MODE_REVERSE    = 16'd5;
    localparam logic [15:0] MODE_CURSOR     = 16'd25;
    localparam logic [15:0] MODE_ALT_SCREEN = 16'd47;
    localparam logic [15:0] MODE_VIS_HIDE   = 16'd5;

    localparam logic [7:0]  COLS_WIDE   = 8'd132;
    localparam logic [7:0]  COLS_NARROW = 8'd80;
    localparam logic [15:0] PARAM_MAX   = 16'hFFFF;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SGR,
        OP_CLEAR_LINE,
        OP_CLEAR_SCREEN,
        OP_CURSOR,
        OP_PRIV_SET,
        OP_PRIV_RESET,
        OP_VIS_SET,
        OP_VIS_RESET
    } op_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  char_code;
        logic [7:0]  attribute;
        logic [1:0]  clear_mode;
        logic [14:0] column;
        logic [14:0] row;
        logic        keep_row;
        logic [7:0]  column_count;
        logic        cursor_visible;
        logic        last;
    } res_t;

    typedef struct packed {
        logic accept;
        logic fetch;
        logic eval;
        logic flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic exec;
        logic walk_done;
        logic eval_blocked;
        logic flush_blocked;
        logic out_free;
    } dp_status_t;

    function automatic logic [7:0] swap_nibbles(input logic [7:0] a);
        return {a[3:0], a[7:4]};
    endfunction

    function automatic logic [7:0] sgr_apply(input logic [7:0] a, input logic present,
                                             input logic [15:0] v);
        logic [2:0] d;
        d = v[2:0];
        if (!present || v == SGR_DEFAULT || v == SGR_DEFAULT_ALT)
            return RESET_ATTR;
        else if (v == SGR_BOLD || v == SGR_UNDERLINE || v == SGR_BLINK)
            return a | 8'h08;
        else if (v == SGR_NORMAL || v == SGR_NO_UNDERLINE || v == SGR_NO_BLINK)
            return a & 8'hF7;
        else if (v == SGR_REVERSE || v == SGR_NO_REVERSE)
            return swap_nibbles(a);
        else if (v >= SGR_FG_FIRST && v <= SGR_FG_LAST)
        begin
            d = 3'(v - SGR_FG_FIRST);
            return {a[7:3], d[0], d[1], d[2]};
        end
        else if (v >= SGR_BG_FIRST && v <= SGR_BG_LAST)
        begin
            d = 3'(v - SGR_BG_FIRST);
            return {a[7], d[0], d[1], d[2], a[3:0]};
        end
        else
            return a;
    endfunction

endpackage

`default_nettype wire

FILE: design/csi_ram.sv
`default_nettype none

module csi_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/csi_ctrl.sv
`default_nettype none

module csi_ctrl import csi_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_stall,
    input  wire dp_status_t status,
    output      ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EVAL,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != ST_IDLE) || !status.out_free;

    always_comb
    begin
        cmd.accept = in_valid && !in_stall;
        cmd.fetch  = (state_reg == ST_FETCH);
        cmd.eval   = (state_reg == ST_EVAL) && !status.eval_blocked;
        cmd.flush  = (state_reg == ST_FLUSH) && !status.flush_blocked;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && status.exec)
                    state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (cmd.eval)
                    state_next = status.walk_done ? ST_FLUSH : ST_FETCH;
            end
            ST_FLUSH:
            begin
                if (cmd.flush)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

FILE: design/csi_datapath.sv
`default_nettype none

module csi_datapath import csi_pkg::*; #(
    parameter int MAX_PARAMS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  byte_in,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [14:0] cfg_data,
    input  wire logic        out_stall,
    input  wire ctrl_cmd_t   cmd,
    output      dp_status_t  status,
    output      res_t        out_res,
    output      logic        out_valid
);

    localparam int IDX_W = $clog2(MAX_PARAMS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PARAMS - 1);

    // Sequence state
    logic             in_seq_reg;
    logic [1:0]       mod_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             cur_present_reg;
    logic [15:0]      cur_value_reg;
    logic [7:0]       attr_reg;

    // Window registers
    logic [14:0] win_left_reg, win_top_reg, win_right_reg, win_bottom_reg;

    // Walk state
    op_t              op_reg;
    logic [IDX_W-1:0] end_idx_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             v0_present_reg, v1_present_reg;
    logic [15:0]      v0_value_reg, v1_value_reg;

    // Held result and output register
    logic hold_valid_reg;
    res_t hold_reg;
    logic out_valid_reg;
    res_t out_reg;

    // RAM
    logic        ram_we;
    logic [16:0] ram_rdata;

    // Byte decode
    logic        is_digit, is_semi, is_final, semi_ok;
    logic [3:0]  digit;
    logic [19:0] acc;
    logic [15:0] digit_value;
    op_t         final_op;
    logic [IDX_W-1:0] final_end_idx;

    // Per-entry and end-of-walk results
    logic        entry_present;
    logic [15:0] entry_value;
    logic        priv_set;
    logic        eval_emit;
    res_t        eval_res;
    logic        fin_emit;
    res_t        fin_res;
    logic        flush_emit;
    logic        out_free;
    logic        out_load;
    res_t        out_next;

    logic signed [17:0] col_raw, row_raw, col_clamp, row_clamp;
    logic               keep;

    assign out_free = !out_valid_reg || !out_stall;

    assign is_digit = (byte_in >= CH_DIGIT_0) && (byte_in <= CH_DIGIT_9);
    assign is_semi  = (byte_in == CH_SEMI);
    assign semi_ok  = is_semi && (idx_reg != LAST_IDX);
    assign is_final = in_seq_reg && !is_digit && !is_semi && (byte_in != CH_LBRACKET)
                      && (byte_in != CH_QUERY) && (byte_in != CH_GREATER);
    assign digit    = 4'(byte_in - CH_DIGIT_0);

    // Multiply by ten as two shifted adds; the sum cannot exceed 20 bits.
    assign acc = {1'b0, cur_value_reg, 3'b000} + {3'b000, cur_value_reg, 1'b0}
                 + {16'd0, digit};

    always_comb
    begin
        if (!cur_present_reg)
            digit_value = {12'd0, digit};
        else if (acc > {4'd0, PARAM_MAX})
            digit_value = PARAM_MAX;
        else
            digit_value = acc[15:0];
    end

    always_comb
    begin
        unique case (byte_in)
            CH_SGR:         final_op = OP_SGR;
            CH_EL:          final_op = OP_CLEAR_LINE;
            CH_ED:          final_op = OP_CLEAR_SCREEN;
            CH_CUP, CH_HVP: final_op = OP_CURSOR;
            CH_SET:
            begin
                if (mod_reg == MOD_QUERY)
                    final_op = OP_PRIV_SET;
                else if (mod_reg == MOD_GREATER)
                    final_op = OP_VIS_SET;
                else
                    final_op = OP_NONE;
            end
            CH_RESET:
            begin
                if (mod_reg == MOD_QUERY)
                    final_op = OP_PRIV_RESET;
                else if (mod_reg == MOD_GREATER)
                    final_op = OP_VIS_RESET;
                else
                    final_op = OP_NONE;
            end
            default:        final_op = OP_NONE;
        endcase
    end

    always_comb
    begin
        unique case (final_op)
            OP_SGR, OP_PRIV_SET, OP_PRIV_RESET:
                final_end_idx = idx_reg;
            OP_CURSOR:
                final_end_idx = (idx_reg == '0) ? '0 : IDX_W'(1);
            default:
                final_end_idx = '0;
        endcase
    end

    // The open parameter is written back on ';' and on the final byte, so the
    // walk only ever reads entries written during this sequence.
    assign ram_we = cmd.accept && in_seq_reg && (semi_ok || is_final);

    csi_ram #(
        .WIDTH (17),
        .DEPTH (MAX_PARAMS)
    ) u_param_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata ({cur_present_reg, cur_value_reg}),
        .re    (cmd.fetch),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign entry_present = ram_rdata[16];
    assign entry_value   = ram_rdata[15:0];
    assign priv_set      = (op_reg == OP_PRIV_SET);

    // Private modes emit one result per matching parameter.
    always_comb
    begin
        eval_res           = '0;
        eval_res.attribute = attr_reg;
        eval_emit          = 1'b0;
        if ((op_reg == OP_PRIV_SET || op_reg == OP_PRIV_RESET) && entry_present)
        begin
            if (entry_value == MODE_COLUMNS)
            begin
                eval_emit             = 1'b1;
                eval_res.kind         = KIND_COLUMNS;
                eval_res.column_count = priv_set ? COLS_WIDE : COLS_NARROW;
            end
            else if (entry_value == MODE_REVERSE)
            begin
                eval_emit          = 1'b1;
                eval_res.kind      = KIND_ATTRIBUTE;
                eval_res.attribute = swap_nibbles(attr_reg);
            end
            else if (entry_value == MODE_CURSOR)
            begin
                eval_emit               = 1'b1;
                eval_res.kind           = KIND_VISIBILITY;
                eval_res.cursor_visible = priv_set;
            end
            else if (entry_value == MODE_ALT_SCREEN && priv_set)
            begin
                eval_emit     = 1'b1;
                eval_res.kind = KIND_CURSOR;
            end
        end
    end

    // Cursor target in signed form, so value-1 may go below zero, then clamped.
    always_comb
    begin
        keep    = 1'b0;
        row_raw = '0;
        if (v0_present_reg)
        begin
            if (v1_present_reg)
            begin
                row_raw = $signed({3'b000, win_top_reg}) + $signed({2'b00, v0_value_reg})
                          - 18'sd1;
                col_raw = $signed({2'b00, v1_value_reg}) - 18'sd1;
            end
            else
            begin
                col_raw = $signed({2'b00, v0_value_reg}) - 18'sd1;
                keep    = 1'b1;
            end
        end
        else
        begin
            col_raw = '0;
            row_raw = $signed({3'b000, win_top_reg});
        end

        if (col_raw < $signed({3'b000, win_left_reg}))
            col_clamp = $signed({3'b000, win_left_reg});
        else if (col_raw > $signed({3'b000, win_right_reg}))
            col_clamp = $signed({3'b000, win_right_reg});
        else
            col_clamp = col_raw;

        if (keep)
            row_clamp = '0;
        else if (row_raw < $signed({3'b000, win_top_reg}))
            row_clamp = $signed({3'b000, win_top_reg});
        else if (row_raw > $signed({3'b000, win_bottom_reg}))
            row_clamp = $signed({3'b000, win_bottom_reg});
        else
            row_clamp = row_raw;
    end

    always_comb
    begin
        fin_res           = '0;
        fin_res.attribute = attr_reg;
        fin_emit          = 1'b0;
        unique case (op_reg)
            OP_SGR:
            begin
                fin_emit     = 1'b1;
                fin_res.kind = KIND_ATTRIBUTE;
            end
            OP_CLEAR_LINE, OP_CLEAR_SCREEN:
            begin
                fin_emit     = 1'b1;
                fin_res.kind = (op_reg == OP_CLEAR_LINE) ? KIND_CLEAR_LINE
                                                         : KIND_CLEAR_SCREEN;
                if (v0_present_reg && v0_value_reg == {14'd0, CLR_FROM_START})
                    fin_res.clear_mode = CLR_FROM_START;
                else if (v0_present_reg && v0_value_reg == {14'd0, CLR_ALL})
                    fin_res.clear_mode = CLR_ALL;
                else
                    fin_res.clear_mode = CLR_TO_END;
            end
            OP_CURSOR:
            begin
                fin_emit         = 1'b1;
                fin_res.kind     = KIND_CURSOR;
                fin_res.column   = col_clamp[14:0];
                fin_res.row      = row_clamp[14:0];
                fin_res.keep_row = keep;
            end
            OP_VIS_SET, OP_VIS_RESET:
            begin
                fin_emit               = v0_present_reg && (v0_value_reg == MODE_VIS_HIDE);
                fin_res.kind           = KIND_VISIBILITY;
                fin_res.cursor_visible = (op_reg == OP_VIS_RESET);
            end
            default:
            begin
                fin_emit = 1'b0;
            end
        endcase
    end

    assign flush_emit = hold_valid_reg || fin_emit;

    always_comb
    begin
        status.exec          = is_final && (final_op != OP_NONE);
        status.walk_done     = (rd_idx_reg == end_idx_reg);
        status.eval_blocked  = eval_emit && hold_valid_reg && !out_free;
        status.flush_blocked = flush_emit && !out_free;
        status.out_free      = out_free;
    end

    // Output register load: a text byte, a held result pushed out by a newer
    // one, or the closing result of a sequence.
    always_comb
    begin
        out_load = 1'b0;
        out_next = hold_reg;
        if (cmd.accept && !in_seq_reg && byte_in != CH_ESC)
        begin
            out_load           = 1'b1;
            out_next           = '0;
            out_next.kind      = KIND_CHAR;
            out_next.char_code = byte_in;
            out_next.attribute = attr_reg;
            out_next.last      = 1'b1;
        end
        else if (cmd.eval && eval_emit && hold_valid_reg)
        begin
            out_load      = 1'b1;
            out_next      = hold_reg;
            out_next.last = 1'b0;
        end
        else if (cmd.flush && flush_emit)
        begin
            out_load      = 1'b1;
            out_next      = hold_valid_reg ? hold_reg : fin_res;
            out_next.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_seq_reg      <= 1'b0;
            mod_reg         <= MOD_NONE;
            idx_reg         <= '0;
            cur_present_reg <= 1'b0;
            attr_reg        <= RESET_ATTR;
            win_left_reg    <= '0;
            win_top_reg     <= '0;
            win_right_reg   <= RESET_WIN_RIGHT;
            win_bottom_reg  <= RESET_WIN_BOTTOM;
            op_reg          <= OP_NONE;
            end_idx_reg     <= '0;
            rd_idx_reg      <= '0;
            v0_present_reg  <= 1'b0;
            v1_present_reg  <= 1'b0;
            hold_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_INIT_ATTR:  attr_reg       <= cfg_data[7:0];
                    REG_WIN_LEFT:   win_left_reg   <= cfg_data;
                    REG_WIN_TOP:    win_top_reg    <= cfg_data;
                    REG_WIN_RIGHT:  win_right_reg  <= cfg_data;
                    REG_WIN_BOTTOM: win_bottom_reg <= cfg_data;
                    default:        ;
                endcase
            end

            if (cmd.accept)
            begin
                if (!in_seq_reg)
                begin
                    if (byte_in == CH_ESC)
                    begin
                        in_seq_reg      <= 1'b1;
                        mod_reg         <= MOD_NONE;
                        idx_reg         <= '0;
                        cur_present_reg <= 1'b0;
                    end
                end
                else if (is_digit)
                begin
                    cur_present_reg <= 1'b1;
                end
                else if (semi_ok)
                begin
                    idx_reg         <= idx_reg + IDX_W'(1);
                    cur_present_reg <= 1'b0;
                end
                else if (byte_in == CH_QUERY)
                begin
                    mod_reg <= MOD_QUERY;
                end
                else if (byte_in == CH_GREATER)
                begin
                    mod_reg <= MOD_GREATER;
                end
                else if (is_final)
                begin
                    in_seq_reg     <= 1'b0;
                    op_reg         <= final_op;
                    end_idx_reg    <= final_end_idx;
                    rd_idx_reg     <= '0;
                    v1_present_reg <= 1'b0;
                end
            end

            if (cmd.eval)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                if (rd_idx_reg == '0)
                    v0_present_reg <= entry_present;
                else
                    v1_present_reg <= entry_present;
                if (op_reg == OP_SGR)
                    attr_reg <= sgr_apply(attr_reg, entry_present, entry_value);
                else if (eval_emit && entry_value == MODE_REVERSE)
                    attr_reg <= swap_nibbles(attr_reg);
                if (eval_emit)
                    hold_valid_reg <= 1'b1;
            end

            if (cmd.flush)
            begin
                hold_valid_reg <= 1'b0;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_seq_reg && is_digit)
            cur_value_reg <= digit_value;
        if (cmd.eval)
        begin
            if (rd_idx_reg == '0)
                v0_value_reg <= entry_value;
            else
                v1_value_reg <= entry_value;
            if (eval_emit)
                hold_reg <= eval_res;
        end
        if (out_load)
            out_reg <= out_next;
    end

    assign out_res   = out_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: design/ansi_csi_sequence_decoder.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  byte_in
// output    out        out_valid/out_stall result_kind .. last
// config    in         cfg_we             cfg_index, cfg_data
//
// Text bytes and sequence bytes other than the final byte are taken while the
// controller is idle and the output register is free. A final byte that executes
// walks the parameter RAM, each entry read and then evaluated, and closes with
// a flush step; SGR and private modes walk every parameter, cursor moves at most
// two, the rest one. The walk waits on a stalled output register only when it
// has a result to push out. Reset is asynchronous; no clearing pass is needed.
module ansi_csi_sequence_decoder import csi_pkg::*; #(
    parameter int MAX_PARAMS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic [7:0]  byte_in,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic [2:0]  result_kind,
    output      logic [7:0]  char_code,
    output      logic [7:0]  attribute,
    output      logic [1:0]  clear_mode,
    output      logic [14:0] column,
    output      logic [14:0] row,
    output      logic        keep_row,
    output      logic [7:0]  column_count,
    output      logic        cursor_visible,
    output      logic        last,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [14:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    res_t       res;

    csi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    csi_datapath #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status),
        .out_res   (res),
        .out_valid (out_valid)
    );

    assign result_kind    = res.kind;
    assign char_code      = res.char_code;
    assign attribute      = res.attribute;
    assign clear_mode     = res.clear_mode;
    assign column         = res.column;
    assign row            = res.row;
    assign keep_row       = res.keep_row;
    assign column_count   = res.column_count;
    assign cursor_visible = res.cursor_visible;
    assign last           = res.last;

endmodule

`default_nettype wire
